// ===== src/matrix_vector_multiply_macros.svh =====
// Assertion macros for the matrix-vector multiply top level.
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define MVM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define MVM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/mvm_pkg.sv =====
// Types, constants and helpers of the matrix-vector multiply block.
`default_nettype none
package mvm_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WDEPTH  = MAX_ROWS * MAX_COLS;
  localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  localparam int CFG_W    = 5;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int ACC_W    = 40;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [0:0] {
    REQ_WEIGHT = 1'b0,
    REQ_VECTOR = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_row;
    logic signed [ACC_W-1:0] row_sum;
    logic                    last_row;
  } result_t;

  // One row operation handed from the sequencer to the MAC pipeline.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic             last;
  } issue_t;

  // Index of the last row in use, register saturated to 1..MAX_ROWS.
  function automatic logic [ROW_W-1:0] rows_last(logic [CFG_W-1:0] r);
    if (r == '0) return '0;
    if (int'(r) > MAX_ROWS) return ROW_W'(MAX_ROWS - 1);
    return ROW_W'(int'(r) - 1);
  endfunction

  // Index of the last column in use, register saturated to 1..MAX_COLS.
  function automatic logic [COL_W-1:0] cols_last(logic [CFG_W-1:0] c);
    if (c == '0) return '0;
    if (int'(c) > MAX_COLS) return COL_W'(MAX_COLS - 1);
    return COL_W'(int'(c) - 1);
  endfunction

  function automatic logic [WADDR_W-1:0] w_addr(int unsigned r, int unsigned c);
    return WADDR_W'(r * MAX_COLS + c);
  endfunction

endpackage
`default_nettype wire

// ===== src/mvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/mvm_ctrl.sv =====
// Sequencer: configuration registers, weight writes and row issue per vector element.
`default_nettype none
module mvm_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire mvm_pkg::req_t                  req_i,
  input  wire logic                           cfg_we_i,
  input  wire mvm_pkg::cfg_idx_e              cfg_idx_i,
  input  wire logic [mvm_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                w_we_o,
  output logic [mvm_pkg::WADDR_W-1:0]         w_waddr_o,
  output logic [mvm_pkg::VAL_W-1:0]           w_wdata_o,
  output logic [mvm_pkg::WADDR_W-1:0]         w_raddr_o,
  output mvm_pkg::issue_t                     issue_o,
  output logic signed [mvm_pkg::VAL_W-1:0]    val_o
);
  import mvm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRN1  = 4'b0100,
    ST_DRN2  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        rows_q, cols_q;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [ROW_W-1:0]        rlast_q;
  logic [IDX_W-1:0]        col_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    emit_q;
  logic                    accept;
  logic                    vec_ok;
  logic [COL_W-1:0]        clast;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign clast  = cols_last(cols_q);
  assign vec_ok = (req_i.req_type == REQ_VECTOR) && (int'(req_i.col_index) <= int'(clast));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_RESET;
      cols_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Weight writes land in the store at the accepting edge.
  assign w_we_o    = accept && (req_i.req_type == REQ_WEIGHT) &&
                     (int'(req_i.row_index) < MAX_ROWS) && (int'(req_i.col_index) < MAX_COLS);
  assign w_waddr_o = w_addr(int'(req_i.row_index), int'(req_i.col_index));
  assign w_wdata_o = req_i.value;
  assign w_raddr_o = w_addr(int'(row_q), int'(col_q));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && vec_ok) begin
          state_d = ST_RUN;
          row_d   = '0;
        end
      end
      ST_RUN: begin
        if (row_q == rlast_q) begin
          state_d = ST_DRN1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      // Hold off the next item until the last row's write-back is done.
      ST_DRN1: state_d = ST_DRN2;
      ST_DRN2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && vec_ok) begin
      col_q   <= req_i.col_index;
      val_q   <= req_i.value;
      emit_q  <= (int'(req_i.col_index) == int'(clast));
      rlast_q <= rows_last(rows_q);
    end
  end

  assign issue_o.valid = (state_q == ST_RUN);
  assign issue_o.row   = row_q;
  assign issue_o.emit  = emit_q;
  assign issue_o.last  = (row_q == rlast_q);
  assign val_o         = val_q;

endmodule
`default_nettype wire

// ===== src/mvm_mac.sv =====
// Multiply-accumulate pipeline: product, saturating add, write-back and result output.
`default_nettype none
module mvm_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mvm_pkg::issue_t               issue_i,
  input  wire logic signed [mvm_pkg::VAL_W-1:0] val_i,
  input  wire logic [mvm_pkg::VAL_W-1:0]     w_rdata_i,
  input  wire logic [mvm_pkg::ACC_W-1:0]     acc_rdata_i,
  output logic                               acc_we_o,
  output logic [mvm_pkg::ROW_W-1:0]          acc_waddr_o,
  output logic [mvm_pkg::ACC_W-1:0]          acc_wdata_o,
  output logic                               result_valid_o,
  output mvm_pkg::result_t                   result_o
);
  import mvm_pkg::*;

  issue_t                   s1_q, s2_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [ACC_W-1:0]         acc_d, acc_q;
  logic [MAX_ROWS-1:0]      vld_q;
  logic [ACC_W:0]           sum;
  logic [ACC_W-1:0]         sat;
  logic                     res_valid_q;
  result_t                  res_q;

  // Stage 1: weight and accumulator arrive from the RAMs.
  assign prod_d = $signed(w_rdata_i) * val_i;
  assign acc_d  = vld_q[s1_q.row] ? acc_rdata_i : '0;

  // Stage 2: exact add, clamp to the signed accumulator range.
  always_comb begin
    sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    sat = sum[ACC_W-1:0];
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end
  end

  assign acc_we_o    = s2_q.valid && !s2_q.emit;
  assign acc_waddr_o = s2_q.row;
  assign acc_wdata_o = sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s1_q        <= issue_i;
      s2_q        <= s1_q;
      res_valid_q <= s2_q.valid && s2_q.emit;
      // Drop every accumulator once the final row of a run is out.
      if (s2_q.valid && s2_q.emit && s2_q.last) begin
        vld_q <= '0;
      end else if (acc_we_o) begin
        vld_q[s2_q.row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q           <= prod_d;
    acc_q            <= acc_d;
    res_q.result_row <= IDX_W'(s2_q.row);
    res_q.row_sum    <= sat;
    res_q.last_row   <= s2_q.last;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

// ===== src/matrix_vector_multiply.sv =====
// Top level of the matrix-vector multiply: weight store, accumulator store, sequencer, MAC.
// A weight write does not make the block busy; a new item may follow in the next cycle.
// A vector element keeps the block busy while its rows are issued, one row per cycle through
// the shared multiplier and accumulator read-modify-write, then through drain states DRN1 and DRN2.
// On the last column, results leave the result register in row order, one per cycle.
// Reset sets rows_in_use and cols_in_use to 16 and zeroes all accumulators at once through
// per-row valid bits; the weight store holds no defined value until written.
`default_nettype none
`include "matrix_vector_multiply_macros.svh"
module matrix_vector_multiply (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire mvm_pkg::req_t             req_i,
  input  wire logic                      cfg_we_i,
  input  wire mvm_pkg::cfg_idx_e         cfg_idx_i,
  input  wire logic [mvm_pkg::CFG_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output mvm_pkg::result_t               result_o
);
  import mvm_pkg::*;

  logic                    w_we;
  logic [WADDR_W-1:0]      w_waddr, w_raddr;
  logic [VAL_W-1:0]        w_wdata, w_rdata;
  issue_t                  issue;
  logic signed [VAL_W-1:0] val;
  logic                    acc_we;
  logic [ROW_W-1:0]        acc_waddr;
  logic [ACC_W-1:0]        acc_wdata, acc_rdata;

  mvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .w_we_o     (w_we),
    .w_waddr_o  (w_waddr),
    .w_wdata_o  (w_wdata),
    .w_raddr_o  (w_raddr),
    .issue_o    (issue),
    .val_o      (val)
  );

  mvm_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_weights (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  mvm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_accs (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (issue.row),
    .rdata_o (acc_rdata)
  );

  mvm_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_i        (issue),
    .val_i          (val),
    .w_rdata_i      (w_rdata),
    .acc_rdata_i    (acc_rdata),
    .acc_we_o       (acc_we),
    .acc_waddr_o    (acc_waddr),
    .acc_wdata_o    (acc_wdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `MVM_ASSERT(a_no_acc_hazard, (acc_we && issue.valid) |-> (acc_waddr != issue.row), "accumulator read and write-back hit the same row")
  `MVM_ASSERT(a_result_in_run, result_valid_o |-> $past(busy), "result outside a vector run")
  `MVM_ASSERT(a_gap_after_last, (result_valid_o && result_o.last_row) |=> !result_valid_o, "result right after the final row")
  `MVM_ASSERT_ALWAYS(a_wr_idle, w_we |-> !busy, "weight write while a run is active")

endmodule
`default_nettype wire

// ===== sim/mvm_checker.sv =====
// Scoreboard for the matrix-vector multiply: predicts each row sum and compares emitted results.
module mvm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  mvm_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  mvm_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [mvm_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      result_valid_i,
  input  mvm_pkg::result_t          result_i,
  output int                        pending_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic signed [VAL_W-1:0] weight_mem [MAX_ROWS][MAX_COLS];
  logic signed [ACC_W-1:0] row_acc [MAX_ROWS];
  logic [CFG_W-1:0]        rows_reg;
  logic [CFG_W-1:0]        cols_reg;
  result_t                 expected_sums [$];
  result_t                 want;
  int                      mismatches;

  initial begin
    mismatches = 0;
    pending_o = 0;
    fail_count_o = 0;
  end

  // Saturate a register to 1..limit; zero acts as one.
  function automatic int unsigned in_use(logic [CFG_W-1:0] count, int unsigned limit);
    if (count == '0) return 1;
    if (int'(count) > limit) return limit;
    return int'(count);
  endfunction

  task automatic apply_request(input req_t item);
    int unsigned             nrows;
    int unsigned             ncols;
    longint                  sum;
    logic signed [VAL_W-1:0] elem;
    result_t                 res;
    elem = item.value;
    if (item.req_type == REQ_WEIGHT) begin
      weight_mem[item.row_index][item.col_index] = elem;
      return;
    end
    nrows = in_use(rows_reg, MAX_ROWS);
    ncols = in_use(cols_reg, MAX_COLS);
    if (item.col_index >= ncols) return;
    for (int r = 0; r < nrows; r++) begin
      sum = longint'(row_acc[r]) + longint'(weight_mem[r][item.col_index]) * longint'(elem);
      if (sum > SUM_MAX) sum = SUM_MAX;
      if (sum < SUM_MIN) sum = SUM_MIN;
      row_acc[r] = ACC_W'(sum);
    end
    if (item.col_index == ncols - 1) begin
      for (int r = 0; r < nrows; r++) begin
        res.result_row = IDX_W'(r);
        res.row_sum    = row_acc[r];
        res.last_row   = (r == nrows - 1);
        expected_sums.push_back(res);
      end
      for (int r = 0; r < MAX_ROWS; r++) row_acc[r] = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg = CFG_RESET;
      cols_reg = CFG_RESET;
      for (int r = 0; r < MAX_ROWS; r++) row_acc[r] = '0;
      expected_sums.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result: expected none, got row %0d sum %0d last %0b",
                   $time, result_i.result_row, result_i.row_sum, result_i.last_row);
          mismatches++;
        end else begin
          want = expected_sums.pop_front();
          if (result_i.result_row !== want.result_row) begin
            $display("%0t: result_row expected %0d got %0d",
                     $time, want.result_row, result_i.result_row);
            mismatches++;
          end
          if (result_i.row_sum !== want.row_sum) begin
            $display("%0t: row_sum of row %0d expected %0d got %0d",
                     $time, want.result_row, want.row_sum, result_i.row_sum);
            mismatches++;
          end
          if (result_i.last_row !== want.last_row) begin
            $display("%0t: last_row of row %0d expected %0b got %0b",
                     $time, want.result_row, want.last_row, result_i.last_row);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS: rows_reg = cfg_data_i;
          CFG_COLS: cols_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) apply_request(req_i);
    end
    pending_o    <= expected_sums.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives weight writes, vector elements and register writes into the multiplier.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 12;
  localparam int NUM_PHASES    = 10;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             req;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             result_valid;
  result_t          result;
  int               pending;
  int               fail_count;
  int               cycles = 0;

  bit               written [MAX_ROWS][MAX_COLS];
  int unsigned      rows_active;
  int unsigned      cols_active;
  bit               no_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_vector_multiply u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  mvm_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_i (result_valid),
    .result_i       (result),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [VAL_W-1:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return VAL_W'($urandom_range(0, 1024) - 512);
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Hold start and the request until the block takes the transaction.
  task automatic issue(input req_t item);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_weight(input int unsigned row, input int unsigned col,
                             input logic [VAL_W-1:0] w);
    req_t item;
    item.req_type  = REQ_WEIGHT;
    item.row_index = IDX_W'(row);
    item.col_index = IDX_W'(col);
    item.value     = w;
    issue(item);
    written[row][col] = 1'b1;
  endtask

  // Fill any weight of the column that the element would read before it was ever written.
  task automatic feed_element(input int unsigned col, input logic [VAL_W-1:0] v);
    req_t item;
    if (col < cols_active) begin
      for (int r = 0; r < rows_active; r++) begin
        if (!written[r][col]) load_weight(r, col, rand_q88());
      end
    end
    item.req_type  = REQ_VECTOR;
    item.row_index = IDX_W'($urandom_range(0, 15));
    item.col_index = IDX_W'(col);
    item.value     = v;
    issue(item);
  endtask

  // Drop start and wait until every expected result is out and the block is quiet.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_idx  <= CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_active = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
    cols_active = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_rows [NUM_PHASES];
    logic [CFG_W-1:0] phase_cols [NUM_PHASES];
    int               counted;
    phase_rows = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd2, 5'd16, 5'd7, 5'd17, 5'd16};
    phase_cols = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd16, 5'd1, 5'd9, 5'd5, 5'd16};
    rows_active = MAX_ROWS;
    cols_active = MAX_COLS;
    no_gaps = 1'b0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    req      <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_ROWS;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme weights and elements, writes outside the rows and columns in use,
    // ignored columns, a repeated column.
    set_config(5'd3, 5'd2);
    load_weight(0, 0, 16'h7FFF);
    load_weight(1, 0, 16'h8000);
    load_weight(2, 0, 16'h0000);
    load_weight(0, 1, 16'h8000);
    load_weight(1, 1, 16'h7FFF);
    load_weight(2, 1, 16'h0001);
    load_weight(15, 15, 16'hFFFF);
    load_weight(3, 5, 16'h1234);
    feed_element(0, 16'h7FFF);
    feed_element(1, 16'h8000);
    feed_element(0, 16'h8000);
    feed_element(5, 16'h0100);
    feed_element(15, 16'hFFFF);
    feed_element(0, 16'h8000);
    feed_element(1, 16'h7FFF);
    settle();
    feed_element(0, 16'hFFFF);
    feed_element(1, 16'h0000);

    // Push one sum far up and the other far down, well past 32 bits.
    set_config(5'd2, 5'd2);
    load_weight(0, 0, 16'h8000);
    load_weight(1, 0, 16'h7FFF);
    no_gaps = 1'b1;
    repeat (24) feed_element(0, 16'h8000);
    feed_element(1, 16'h0100);
    no_gaps = 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_rows[p], phase_cols[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          for (int c = 0; c < cols_active; c++) begin
            if ($urandom_range(0, 5) == 0)
              load_weight($urandom_range(0, 15), $urandom_range(0, 15), rand_q88());
            if (cols_active < MAX_COLS && $urandom_range(0, 9) == 0)
              feed_element($urandom_range(cols_active, MAX_COLS - 1), rand_q88());
            // Leave the vector open now and then; the next run piles onto the same sums.
            if (c == cols_active - 1 && $urandom_range(0, 11) == 0) break;
            if ($urandom_range(0, 15) == 0) begin
              feed_element(c, rand_q88());
              counted++;
            end
            feed_element(c, rand_q88());
            counted++;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          load_weight($urandom_range(0, 15), $urandom_range(0, 15), VAL_W'($urandom()));
          counted++;
        end else begin
          feed_element($urandom_range(0, 15), VAL_W'($urandom()));
          counted++;
        end
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
